// ===== rtl/rgb2mono_pkg.sv =====
// ----------------------------------------------------------------------------
// rgb2mono_pkg
// Shared types and constants for the RGB565 to 1-bpp framebuffer writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rgb2mono_pkg;

   localparam int DEF_PANEL_WIDTH  = 800;
   localparam int DEF_PANEL_HEIGHT = 480;

   // 256 bytes per row by 2048 rows at most
   localparam int MAX_ADDR_W  = 19;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] THRESHOLD_RESET = 8'd160;
   localparam logic [7:0] LUMA_COEF_R     = 8'd77;
   localparam logic [7:0] LUMA_COEF_G     = 8'd150;
   localparam logic [7:0] LUMA_COEF_B     = 8'd29;
   localparam logic [7:0] BYTE_WHITE      = 8'hFF;

   localparam int REQ_TDATA_W = 88;
   localparam int RSP_TDATA_W = 48;

   localparam logic CSR_SUPPRESS  = 1'b0;
   localparam logic CSR_THRESHOLD = 1'b1;

   localparam logic RES_READ    = 1'b0;
   localparam logic RES_REFRESH = 1'b1;

   typedef enum logic [1:0] {
      CMD_PIXEL = 2'd0,
      CMD_CHUNK = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      OP_PIXEL = 2'd0,
      OP_READ  = 2'd1,
      OP_FULL  = 2'd2,
      OP_PLAN  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      RK_NONE    = 2'd0,
      RK_FULL    = 2'd1,
      RK_REINIT  = 2'd2,
      RK_PARTIAL = 2'd3
   } refresh_type;

   typedef struct packed {
      op_type                  op;
      logic                    in_range;
      logic [MAX_ADDR_W-1:0]   addr;
      logic [7:0]              mask;
      logic                    white;
      logic signed [11:0]      left;
      logic signed [11:0]      top;
      logic signed [11:0]      right;
      logic signed [11:0]      bottom;
   } qentry_type;

   typedef struct packed {
      logic       valid;
      qentry_type entry;
   } qpush_type;

endpackage

`default_nettype wire

// ===== rtl/rgb565_to_mono_framebuffer_writer.sv =====
// ----------------------------------------------------------------------------
// rgb565_to_mono_framebuffer_writer
// RGB565 pixel stream into a 1-bpp framebuffer with refresh planning.
//
// Request channel (req_*): tuser is the command (pixel write, chunk end,
// byte read), tlast marks the last chunk of a frame update. Result channel
// (rsp_*): tuser 0 carries a framebuffer byte, 1 a refresh command.
// Config port (csr_*): index 0 suppress_refresh, 1 white_threshold; write
// only while the block is idle.
// Throughput: one request per cycle in steady state; pixel read-modify-write
// runs in the back part with a one-entry write forward, so consecutive
// pixels in the same byte do not stall. A result passes from the queue
// through the back stage register into the result register behind rsp_tvalid.
// Reset: a clearing pass writes every framebuffer byte to white, one byte
// per cycle (PANEL_WIDTH/8 rounded up times PANEL_HEIGHT bytes, 48000 at
// default size); req_tready stays low meanwhile.
// When rsp_tready is low the result register holds, the back stage and the
// two-entry queue fill, then req_tready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb565_to_mono_framebuffer_writer #(
   parameter int PANEL_WIDTH  = rgb2mono_pkg::DEF_PANEL_WIDTH,
   parameter int PANEL_HEIGHT = rgb2mono_pkg::DEF_PANEL_HEIGHT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // pos_x, pos_y, pixel, area_left, area_top, area_right, area_bottom
   input  logic [rgb2mono_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // cmd
   input  logic [1:0]                             req_tuser,
   input  logic                                   req_tlast,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // refresh_kind, win_x_start, win_x_end, win_y_low, win_y_high, read_data
   output logic [rgb2mono_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // result_kind
   output logic                                   rsp_tuser,
   input  logic                                   csr_we,
   input  logic                                   csr_index,
   input  logic [7:0]                             csr_wdata
);
   import rgb2mono_pkg::*;

   qpush_type  push;
   qentry_type head;
   logic       q_full, head_valid, pop, clearing;

   rgb2mono_front #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_full     (q_full),
      .clearing   (clearing),
      .push       (push)
   );

   rgb2mono_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   rgb2mono_back #(
      .PANEL_WIDTH  (PANEL_WIDTH),
      .PANEL_HEIGHT (PANEL_HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== rtl/rgb2mono_queue.sv =====
// ----------------------------------------------------------------------------
// rgb2mono_queue
// Short FIFO of classified work between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb2mono_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  rgb2mono_pkg::qpush_type  push,
   output logic                     full,
   input  logic                     pop,
   output logic                     head_valid,
   output rgb2mono_pkg::qentry_type head
);
   import rgb2mono_pkg::*;

   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   qentry_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];

   always_comb begin
      do_push   = push.valid && !full;
      do_pop    = pop && head_valid;
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rgb2mono_front.sv =====
// ----------------------------------------------------------------------------
// rgb2mono_front
// Accepts request transfers, converts pixels to a mono bit, tracks the dirty
// rectangle and refresh state, and queues work for the back part.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb2mono_front #(
   parameter int PANEL_WIDTH  = rgb2mono_pkg::DEF_PANEL_WIDTH,
   parameter int PANEL_HEIGHT = rgb2mono_pkg::DEF_PANEL_HEIGHT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [rgb2mono_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic [1:0]                             req_tuser,
   input  logic                                   req_tlast,
   input  logic                                   csr_we,
   input  logic                                   csr_index,
   input  logic [7:0]                             csr_wdata,
   input  logic                                   q_full,
   input  logic                                   clearing,
   output rgb2mono_pkg::qpush_type                push
);
   import rgb2mono_pkg::*;

   localparam int LINE_BYTES = (PANEL_WIDTH + 7) / 8;
   localparam logic [MAX_ADDR_W-1:0] LINE_BYTES_A = MAX_ADDR_W'(LINE_BYTES);

   logic                suppress_ff;
   logic [7:0]          threshold_ff;
   logic                full_pending_ff, full_pending_in;
   logic                dirty_valid_ff, dirty_valid_in;
   logic signed [11:0]  dirty_left_ff, dirty_left_in;
   logic signed [11:0]  dirty_top_ff, dirty_top_in;
   logic signed [11:0]  dirty_right_ff, dirty_right_in;
   logic signed [11:0]  dirty_bottom_ff, dirty_bottom_in;

   cmd_type             cmd;
   logic                accept;
   logic signed [11:0]  pos_x, pos_y, a_left, a_top, a_right, a_bottom;
   logic [15:0]         pixel;
   logic [7:0]          r8, g8, b8;
   logic [15:0]         luma_sum;
   logic                on_screen, read_ok;
   logic [MAX_ADDR_W-1:0] row_base, pix_addr, rd_addr;

   assign req_tready = !clearing && !q_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd      = cmd_type'(req_tuser);
      pos_x    = req_tdata[11:0];
      pos_y    = req_tdata[23:12];
      pixel    = req_tdata[39:24];
      a_left   = req_tdata[51:40];
      a_top    = req_tdata[63:52];
      a_right  = req_tdata[75:64];
      a_bottom = req_tdata[87:76];

      r8 = {pixel[15:11], pixel[15:13]};
      g8 = {pixel[10:5], pixel[10:9]};
      b8 = {pixel[4:0], pixel[4:2]};
      luma_sum = 16'(r8) * 16'(LUMA_COEF_R) + 16'(g8) * 16'(LUMA_COEF_G)
               + 16'(b8) * 16'(LUMA_COEF_B);

      on_screen = !pos_x[11] && ({1'b0, pos_x[10:0]} < 12'(PANEL_WIDTH))
               && !pos_y[11] && ({1'b0, pos_y[10:0]} < 12'(PANEL_HEIGHT));
      read_ok   = !pos_x[11] && ({1'b0, pos_x[10:0]} < 12'(LINE_BYTES))
               && !pos_y[11] && ({1'b0, pos_y[10:0]} < 12'(PANEL_HEIGHT));

      row_base = MAX_ADDR_W'(pos_y[10:0]) * LINE_BYTES_A;
      pix_addr = row_base + MAX_ADDR_W'(pos_x[10:3]);
      rd_addr  = row_base + MAX_ADDR_W'(pos_x[10:0]);

      // merged dirty rectangle
      if (!dirty_valid_ff) begin
         dirty_left_in   = a_left;
         dirty_top_in    = a_top;
         dirty_right_in  = a_right;
         dirty_bottom_in = a_bottom;
      end else begin
         dirty_left_in   = (a_left < dirty_left_ff) ? a_left : dirty_left_ff;
         dirty_top_in    = (a_top < dirty_top_ff) ? a_top : dirty_top_ff;
         dirty_right_in  = (a_right > dirty_right_ff) ? a_right : dirty_right_ff;
         dirty_bottom_in = (a_bottom > dirty_bottom_ff) ? a_bottom : dirty_bottom_ff;
      end

      full_pending_in       = full_pending_ff;
      dirty_valid_in        = dirty_valid_ff;
      push                  = '0;
      push.entry.left       = dirty_left_in;
      push.entry.top        = dirty_top_in;
      push.entry.right      = dirty_right_in;
      push.entry.bottom     = dirty_bottom_in;
      push.entry.mask       = 8'h80 >> pos_x[2:0];
      push.entry.white      = (luma_sum[15:8] >= threshold_ff);

      if (accept) begin
         case (cmd)
            CMD_PIXEL: begin
               push.valid          = on_screen;
               push.entry.op       = OP_PIXEL;
               push.entry.in_range = 1'b1;
               push.entry.addr     = pix_addr;
            end
            CMD_CHUNK: begin
               dirty_valid_in = !req_tlast;
               if (req_tlast && !suppress_ff) begin
                  push.valid      = 1'b1;
                  push.entry.op   = full_pending_ff ? OP_FULL : OP_PLAN;
                  full_pending_in = 1'b0;
               end
            end
            CMD_READ: begin
               push.valid          = 1'b1;
               push.entry.op       = OP_READ;
               push.entry.in_range = read_ok;
               push.entry.addr     = rd_addr;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         suppress_ff     <= 1'b0;
         threshold_ff    <= THRESHOLD_RESET;
         full_pending_ff <= 1'b1;
         dirty_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SUPPRESS:  suppress_ff  <= csr_wdata[0];
               CSR_THRESHOLD: threshold_ff <= csr_wdata;
               default: ;
            endcase
         end
         full_pending_ff <= full_pending_in;
         dirty_valid_ff  <= dirty_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && cmd == CMD_CHUNK) begin
         dirty_left_ff   <= dirty_left_in;
         dirty_top_ff    <= dirty_top_in;
         dirty_right_ff  <= dirty_right_in;
         dirty_bottom_ff <= dirty_bottom_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rgb2mono_back.sv =====
// ----------------------------------------------------------------------------
// rgb2mono_back
// Owns the framebuffer memory: clearing pass, pixel read-modify-write with
// write forwarding, byte reads, refresh window planning and the result
// register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb2mono_back #(
   parameter int PANEL_WIDTH  = rgb2mono_pkg::DEF_PANEL_WIDTH,
   parameter int PANEL_HEIGHT = rgb2mono_pkg::DEF_PANEL_HEIGHT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   head_valid,
   input  rgb2mono_pkg::qentry_type               head,
   output logic                                   pop,
   output logic                                   clearing,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [rgb2mono_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                                   rsp_tuser
);
   import rgb2mono_pkg::*;

   localparam int LINE_BYTES  = (PANEL_WIDTH + 7) / 8;
   localparam int FRAME_BYTES = LINE_BYTES * PANEL_HEIGHT;
   localparam int AW          = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
   localparam logic [10:0] LIM_X   = 11'(PANEL_WIDTH - 1);
   localparam logic [10:0] LIM_Y   = 11'(PANEL_HEIGHT - 1);
   localparam logic [10:0] NEAR_X  = 11'(PANEL_WIDTH - 8);
   localparam logic [11:0] WIDTH_C = 12'(PANEL_WIDTH);
   localparam logic [11:0] HEIGHT_C = 12'(PANEL_HEIGHT);

   function automatic logic [10:0] clamp_pos(logic signed [11:0] v, logic [10:0] hi);
      logic [10:0] res;
      if (v[11]) begin
         res = '0;
      end else if (v[10:0] > hi) begin
         res = hi;
      end else begin
         res = v[10:0];
      end
      return res;
   endfunction

   logic [7:0]     frame_mem [FRAME_BYTES];
   logic [7:0]     rdata_ff;

   logic           clear_busy_ff, clear_busy_in;
   logic [AW-1:0]  clear_cnt_ff, clear_cnt_in;

   logic           b_valid_ff, b_valid_in;
   op_type         b_op_ff;
   logic           b_in_range_ff;
   logic [AW-1:0]  b_addr_ff;
   logic [7:0]     b_mask_ff;
   logic           b_white_ff;
   refresh_type    b_rk_ff;
   logic [9:0]     b_xs_ff, b_xe_ff;
   logic [8:0]     b_yl_ff, b_yh_ff;

   logic           fwd_valid_ff, fwd_valid_in;
   logic [AW-1:0]  fwd_addr_ff;
   logic [7:0]     fwd_data_ff;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic           rsp_user_ff;

   logic           out_free, b_ready, b_is_pixel, rsp_load;
   logic           mem_we;
   logic [AW-1:0]  mem_waddr;
   logic [7:0]     mem_wdata, cur_byte, new_byte;

   logic [10:0]    x1, y1, x2, y2;
   logic [11:0]    x2_up, xe_raw, xe_cl, yh_raw;
   logic [10:0]    yl_raw;
   logic           near_full;
   refresh_type    a_rk;
   logic [9:0]     a_xs, a_xe;
   logic [8:0]     a_yl, a_yh;

   assign clearing   = clear_busy_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // refresh planning from the queue head
   always_comb begin
      x1 = clamp_pos(head.left, LIM_X);
      y1 = clamp_pos(head.top, LIM_Y);
      x2 = clamp_pos(head.right, LIM_X);
      y2 = clamp_pos(head.bottom, LIM_Y);
      near_full = (x1 == '0) && (y1 == '0) && (x2 >= NEAR_X) && (y2 == LIM_Y);
      x2_up  = {1'b0, x2} + 12'd7;
      xe_raw = {x2_up[11:3], 3'b000};
      xe_cl  = (xe_raw > WIDTH_C) ? WIDTH_C : xe_raw;
      yl_raw = LIM_Y - y2;
      yh_raw = HEIGHT_C - {1'b0, y1};

      a_rk = RK_NONE;
      a_xs = '0;
      a_xe = '0;
      a_yl = '0;
      a_yh = '0;
      case (head.op)
         OP_FULL: a_rk = RK_FULL;
         OP_PLAN: begin
            if (near_full) begin
               a_rk = RK_REINIT;
            end else begin
               a_rk = RK_PARTIAL;
               a_xs = {x1[9:3], 3'b000};
               a_xe = xe_cl[9:0];
               a_yl = yl_raw[8:0];
               a_yh = yh_raw[8:0];
            end
         end
         default: ;
      endcase
   end

   // stage B: merge, write back, result
   always_comb begin
      out_free   = !rsp_valid_ff || rsp_tready;
      b_is_pixel = (b_op_ff == OP_PIXEL);
      b_ready    = !b_valid_ff || b_is_pixel || out_free;
      pop        = head_valid && b_ready;
      b_valid_in = pop ? 1'b1 : (b_ready ? 1'b0 : b_valid_ff);

      cur_byte = (fwd_valid_ff && fwd_addr_ff == b_addr_ff) ? fwd_data_ff : rdata_ff;
      new_byte = b_white_ff ? (cur_byte | b_mask_ff) : (cur_byte & ~b_mask_ff);

      fwd_valid_in = b_valid_ff && b_is_pixel;

      if (clear_busy_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clear_cnt_ff;
         mem_wdata = BYTE_WHITE;
      end else begin
         mem_we    = b_valid_ff && b_is_pixel;
         mem_waddr = b_addr_ff;
         mem_wdata = new_byte;
      end

      clear_cnt_in  = clear_cnt_ff + AW'(1);
      clear_busy_in = clear_busy_ff && (clear_cnt_ff != AW'(FRAME_BYTES - 1));

      rsp_load     = b_valid_ff && !b_is_pixel && out_free;
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_waddr] <= mem_wdata;
      end
      if (b_ready) begin
         rdata_ff <= frame_mem[head.addr[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_cnt_ff  <= '0;
         b_valid_ff    <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         if (clear_busy_ff) begin
            clear_cnt_ff <= clear_cnt_in;
         end
         b_valid_ff   <= b_valid_in;
         if (b_ready) begin
            fwd_valid_ff <= fwd_valid_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready) begin
         fwd_addr_ff   <= b_addr_ff;
         fwd_data_ff   <= new_byte;
         b_op_ff       <= head.op;
         b_in_range_ff <= head.in_range;
         b_addr_ff     <= head.addr[AW-1:0];
         b_mask_ff     <= head.mask;
         b_white_ff    <= head.white;
         b_rk_ff       <= a_rk;
         b_xs_ff       <= a_xs;
         b_xe_ff       <= a_xe;
         b_yl_ff       <= a_yl;
         b_yh_ff       <= a_yh;
      end
      if (rsp_load) begin
         if (b_op_ff == OP_READ) begin
            rsp_user_ff <= RES_READ;
            rsp_data_ff <= {(b_in_range_ff ? cur_byte : 8'h00), 40'd0};
         end else begin
            rsp_user_ff <= RES_REFRESH;
            rsp_data_ff <= {8'h00, b_yh_ff, b_yl_ff, b_xe_ff, b_xs_ff, b_rk_ff};
         end
      end
   end

endmodule

`default_nettype wire

// ===== verif/mono_fb_checker.sv =====
// ----------------------------------------------------------------------------
// mono_fb_checker
// Watches the request, response and CSR ports of the RGB565 to 1-bpp
// framebuffer writer. Keeps its own framebuffer image, dirty rectangle and
// refresh state, predicts the response of every request transfer and
// compares each response transfer field by field with the oldest one owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mono_fb_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   input  logic                                   req_tready,
   input  logic [rgb2mono_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic [1:0]                             req_tuser,
   input  logic                                   req_tlast,
   input  logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   input  logic [rgb2mono_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                                   rsp_tuser,
   input  logic                                   csr_we,
   input  logic                                   csr_index,
   input  logic [7:0]                             csr_wdata,
   output int                                     error_count,
   output int                                     pending_count
);
   import rgb2mono_pkg::*;

   localparam int PANEL_W     = DEF_PANEL_WIDTH;
   localparam int PANEL_H     = DEF_PANEL_HEIGHT;
   localparam int LINE_BYTES  = (PANEL_W + 7) / 8;
   localparam int FRAME_BYTES = LINE_BYTES * PANEL_H;
   localparam int COEF_R      = 77;
   localparam int COEF_G      = 150;
   localparam int COEF_B      = 29;

   typedef struct packed {
      logic        kind;
      refresh_type rk;
      logic [9:0]  x_start;
      logic [9:0]  x_end;
      logic [8:0]  y_low;
      logic [8:0]  y_high;
      logic [7:0]  data;
   } fb_rsp_type;

   logic [7:0]         frame [FRAME_BYTES];
   bit                 full_pending;
   bit                 dirty_valid;
   logic signed [11:0] dirty_l, dirty_t, dirty_r, dirty_b;
   bit                 suppress;
   logic [7:0]         threshold;
   fb_rsp_type         owed_rsp [$];
   int                 miss_total = 0;

   assign error_count = miss_total;

   task automatic report_miss(string what, int got, int want);
      $display("ERROR t=%0t %s: got 0x%0h expected 0x%0h", $time, what, got, want);
      miss_total++;
   endtask

   function automatic int clamp_to(int v, int hi);
      return (v < 0) ? 0 : ((v > hi) ? hi : v);
   endfunction

   function automatic void paint_pixel(int x, int y, logic [15:0] rgb);
      logic [7:0] r, g, b, bitmask;
      int         luma, idx;
      if (x < 0 || x >= PANEL_W || y < 0 || y >= PANEL_H) return;
      r = {rgb[15:11], rgb[15:13]};
      g = {rgb[10:5], rgb[10:9]};
      b = {rgb[4:0], rgb[4:2]};
      luma = (r * COEF_R + g * COEF_G + b * COEF_B) >> 8;
      idx = y * LINE_BYTES + x / 8;
      bitmask = 8'h80 >> (x % 8);
      if (luma >= threshold) frame[idx] = frame[idx] | bitmask;
      else frame[idx] = frame[idx] & ~bitmask;
   endfunction

   function automatic fb_rsp_type plan_refresh();
      fb_rsp_type res;
      int         x1, y1, x2, y2, ax1, ax2;
      res = '0;
      res.kind = RES_REFRESH;
      if (full_pending) begin
         full_pending = 1'b0;
         res.rk = RK_FULL;
         return res;
      end
      x1 = clamp_to(int'(dirty_l), PANEL_W - 1);
      y1 = clamp_to(int'(dirty_t), PANEL_H - 1);
      x2 = clamp_to(int'(dirty_r), PANEL_W - 1);
      y2 = clamp_to(int'(dirty_b), PANEL_H - 1);
      if (x1 == 0 && y1 == 0 && x2 >= PANEL_W - 8 && y2 == PANEL_H - 1) begin
         res.rk = RK_REINIT;
         return res;
      end
      ax1 = (x1 / 8) * 8;
      ax2 = ((x2 + 7) / 8) * 8 - 1;
      if (ax2 >= PANEL_W) ax2 = PANEL_W - 1;
      res.rk      = RK_PARTIAL;
      res.x_start = 10'(ax1);
      res.x_end   = 10'(ax2 + 1);
      res.y_low   = 9'(PANEL_H - 1 - y2);
      res.y_high  = 9'(PANEL_H - y1);
      return res;
   endfunction

   always @(posedge clock) begin
      fb_rsp_type         got, want;
      logic signed [11:0] al, at, ar, ab;
      int                 col, row;
      if (reset) begin
         for (int i = 0; i < FRAME_BYTES; i++) frame[i] = BYTE_WHITE;
         full_pending = 1'b1;
         dirty_valid = 1'b0;
         dirty_l = '0;
         dirty_t = '0;
         dirty_r = '0;
         dirty_b = '0;
         suppress = 1'b0;
         threshold = THRESHOLD_RESET;
         owed_rsp.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_SUPPRESS) suppress = csr_wdata[0];
            else threshold = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            col = int'($signed(req_tdata[11:0]));
            row = int'($signed(req_tdata[23:12]));
            case (req_tuser)
               CMD_PIXEL: begin
                  paint_pixel(col, row, req_tdata[39:24]);
               end
               CMD_CHUNK: begin
                  al = $signed(req_tdata[51:40]);
                  at = $signed(req_tdata[63:52]);
                  ar = $signed(req_tdata[75:64]);
                  ab = $signed(req_tdata[87:76]);
                  if (!dirty_valid) begin
                     dirty_l = al;
                     dirty_t = at;
                     dirty_r = ar;
                     dirty_b = ab;
                     dirty_valid = 1'b1;
                  end else begin
                     if (al < dirty_l) dirty_l = al;
                     if (at < dirty_t) dirty_t = at;
                     if (ar > dirty_r) dirty_r = ar;
                     if (ab > dirty_b) dirty_b = ab;
                  end
                  if (req_tlast) begin
                     if (!suppress) owed_rsp.push_back(plan_refresh());
                     dirty_valid = 1'b0;
                  end
               end
               CMD_READ: begin
                  want = '0;
                  want.kind = RES_READ;
                  want.rk = RK_NONE;
                  if (col >= 0 && col < LINE_BYTES && row >= 0 && row < PANEL_H)
                     want.data = frame[row * LINE_BYTES + col];
                  owed_rsp.push_back(want);
               end
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.kind    = rsp_tuser;
            got.rk      = refresh_type'(rsp_tdata[1:0]);
            got.x_start = rsp_tdata[11:2];
            got.x_end   = rsp_tdata[21:12];
            got.y_low   = rsp_tdata[30:22];
            got.y_high  = rsp_tdata[39:31];
            got.data    = rsp_tdata[47:40];
            if (owed_rsp.size() == 0) begin
               report_miss("response transfer with none outstanding, kind", got.kind, 0);
            end else begin
               want = owed_rsp.pop_front();
               if (got.kind != want.kind) report_miss("result_kind", got.kind, want.kind);
               if (got.rk != want.rk) report_miss("refresh_kind", got.rk, want.rk);
               if (got.x_start != want.x_start)
                  report_miss("win_x_start", got.x_start, want.x_start);
               if (got.x_end != want.x_end) report_miss("win_x_end", got.x_end, want.x_end);
               if (got.y_low != want.y_low) report_miss("win_y_low", got.y_low, want.y_low);
               if (got.y_high != want.y_high)
                  report_miss("win_y_high", got.y_high, want.y_high);
               if (got.data != want.data) report_miss("read_data", got.data, want.data);
            end
         end
      end
      pending_count <= owed_rsp.size();
   end

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Top of the RGB565 to 1-bpp framebuffer writer testbench. Drives a directed
// set of edge-case requests, then phases of random frame updates, reads and
// noise under different CSR settings, with random gaps on the request side,
// random backpressure and one long hold-off on the response side. The
// checker instance predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;
   import rgb2mono_pkg::*;

   localparam int         LINE_BYTES = (DEF_PANEL_WIDTH + 7) / 8;
   localparam int         LIMIT      = 400000;
   localparam int         LONG_HOLD  = 300;
   localparam int         PHASE_LEN  = 225;
   localparam logic [1:0] CMD_SPARE  = 2'd3;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [1:0]             req_tuser  = '0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_we     = 1'b0;
   logic                   csr_index  = 1'b0;
   logic [7:0]             csr_wdata  = '0;

   int error_count;
   int pending_count;
   int items_sent    = 0;
   int gap_pct       = 20;
   int cycle_count   = 0;
   int hold_count;
   bit quiet         = 1'b0;
   bit hold_request  = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rgb565_to_mono_framebuffer_writer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   mono_fb_checker fb_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // tdata: pos_x, pos_y, pixel, area_left, area_top, area_right, area_bottom
   task automatic send_item(input logic [1:0] cmd, input logic [11:0] x, input logic [11:0] y,
                            input logic [15:0] rgb, input logic [11:0] l, input logic [11:0] t,
                            input logic [11:0] r, input logic [11:0] b, input logic last);
      if (!quiet && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tlast  <= last;
      req_tdata  <= {b, r, t, l, rgb, y, x};
      do @(posedge clock); while (!req_tready);
      if (cmd != CMD_SPARE) items_sent++;
   endtask

   task automatic put_pixel(input int x, input int y, input logic [15:0] rgb);
      send_item(CMD_PIXEL, 12'(x), 12'(y), rgb, 12'($urandom), 12'($urandom), 12'($urandom),
                12'($urandom), 1'($urandom));
   endtask

   task automatic read_byte(input int col, input int row);
      send_item(CMD_READ, 12'(col), 12'(row), 16'($urandom), 12'($urandom), 12'($urandom),
                12'($urandom), 12'($urandom), 1'($urandom));
   endtask

   task automatic end_chunk(input int l, input int t, input int r, input int b,
                            input logic last);
      send_item(CMD_CHUNK, 12'($urandom), 12'($urandom), 16'($urandom), 12'(l), 12'(t),
                12'(r), 12'(b), last);
   endtask

   // wait until every owed response is back, then let the pipeline empty
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // response side: random backpressure plus one long hold-off on request
   initial begin
      @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            for (hold_count = 0; hold_count < LONG_HOLD; hold_count++) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   initial begin
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("rgb565_to_mono_framebuffer_writer: mismatch");
      $finish;
   end

   initial begin
      int         phase_end, l, t, w, h, nchunk, sel;
      bit         last;
      logic [7:0] thr;
      bit         sup;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: reset thresholds, extremes, off-screen, out-of-range reads
      read_byte(0, 0);
      put_pixel(0, 0, 16'h0000);
      put_pixel(7, 0, 16'hFFFF);
      put_pixel(799, 479, 16'h0000);
      put_pixel(-1, 0, 16'h0000);
      put_pixel(800, 5, 16'h0000);
      put_pixel(5, 480, 16'h0000);
      put_pixel(-2048, 2047, 16'h0000);
      put_pixel(2047, -2048, 16'h0000);
      read_byte(0, 0);
      read_byte(99, 479);
      read_byte(100, 0);
      read_byte(-1, 0);
      read_byte(0, 480);
      read_byte(2047, -2048);
      send_item(CMD_SPARE, 12'($urandom), 12'($urandom), 16'($urandom), 12'($urandom),
                12'($urandom), 12'($urandom), 12'($urandom), 1'b1);
      end_chunk(10, 10, 20, 20, 1'b0);
      end_chunk(5, 7, 30, 40, 1'b1);
      end_chunk(0, 0, 799, 479, 1'b1);
      end_chunk(-2048, -2048, 2047, 2047, 1'b1);
      end_chunk(0, 0, 792, 479, 1'b1);
      end_chunk(0, 0, 791, 479, 1'b1);
      end_chunk(13, 100, 250, 300, 1'b1);
      end_chunk(300, 200, 100, 50, 1'b1);
      end_chunk(795, 470, 2047, 2047, 1'b1);
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0:       begin sup = 1'b0; thr = 8'd0; end
            1:       begin sup = 1'b1; thr = 8'd255; end
            2:       begin sup = 1'b0; thr = 8'($urandom_range(1, 254)); end
            3:       begin sup = 1'b1; thr = 8'($urandom_range(100, 200)); end
            default: begin sup = 1'b0; thr = THRESHOLD_RESET; end
         endcase
         write_csr(CSR_SUPPRESS, {7'd0, sup});
         write_csr(CSR_THRESHOLD, thr);
         if (ph == 2) hold_request = 1'b1;
         if (ph == 4) quiet = 1'b1;
         phase_end = items_sent + PHASE_LEN;
         while (items_sent < phase_end) begin
            gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 25;
            sel = $urandom_range(0, 9);
            if (sel < 6) begin
               // frame update: pixels inside a small area, chunk ends, last mostly on the final one
               nchunk = $urandom_range(1, 3);
               for (int c = 0; c < nchunk; c++) begin
                  l = $urandom_range(0, 799);
                  t = $urandom_range(0, 479);
                  w = $urandom_range(0, 47);
                  h = $urandom_range(0, 15);
                  last = (c == nchunk - 1) && ($urandom_range(0, 7) != 0);
                  repeat ($urandom_range(1, 8))
                     put_pixel(l + $urandom_range(0, w), t + $urandom_range(0, h), 16'($urandom));
                  if ($urandom_range(0, 1))
                     read_byte((l + $urandom_range(0, w)) / 8, t + $urandom_range(0, h));
                  if ($urandom_range(0, 11) == 0)
                     end_chunk($urandom_range(0, 1) ? 0 : -$urandom_range(1, 2048),
                               $urandom_range(0, 1) ? 0 : -$urandom_range(1, 2048),
                               $urandom_range(792, 2047), $urandom_range(479, 2047), last);
                  else if ($urandom_range(0, 7) == 0)
                     end_chunk(l - $urandom_range(0, 2048), t - $urandom_range(0, 2048),
                               l + w + $urandom_range(0, 1200), t + h + $urandom_range(0, 1500),
                               last);
                  else
                     end_chunk(l, t, l + w, t + h, last);
               end
            end else if (sel < 8) begin
               repeat ($urandom_range(1, 4))
                  read_byte($urandom_range(0, LINE_BYTES - 1), $urandom_range(0, 479));
            end else begin
               send_item(2'($urandom_range(0, 3)), 12'($urandom), 12'($urandom),
                         16'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                         12'($urandom), 1'($urandom));
            end
         end
         drain();
      end

      repeat (10) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("rgb565_to_mono_framebuffer_writer: match");
      end else begin
         $display("rgb565_to_mono_framebuffer_writer: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire
